// File: rtl/char_lcd_nibble_command_encoder_top_assert.svh
// Assertion macros for the character LCD nibble command encoder.
// Included by the checker module; no other dependencies.
`ifndef CHAR_LCD_NIBBLE_COMMAND_ENCODER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_COMMAND_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clne_pkg.sv
// Shared types and constants for the character LCD nibble command encoder.
// No dependencies.
package clne_pkg;

    typedef enum logic [3:0] {
        CMD_INIT      = 4'd0,
        CMD_CHAR      = 4'd1,
        CMD_CURSOR    = 4'd2,
        CMD_DISPLAY   = 4'd3,
        CMD_CUR_SHOW  = 4'd4,
        CMD_BLINK     = 4'd5,
        CMD_SHIFT     = 4'd6,
        CMD_CLEAR     = 4'd7,
        CMD_HOME      = 4'd8,
        CMD_BACKLIGHT = 4'd9
    } t_cmd;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Controller command bytes.
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_HOME       = 8'h02;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_CD_SHIFT   = 8'h10;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h20;
    localparam logic [7:0] LCD_SET_ADDR   = 8'h80;
    localparam logic [6:0] ROW1_OFFSET    = 7'h40;

    localparam logic [2:0] FLAGS_DISP_ON  = 3'b100;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_BYTE,
        JOB_PORT,
        JOB_INIT
    } t_job_kind;

    // One decoded request, as held by the byte sequencer.
    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] data;
        logic       rs;
        logic       bl;
        logic       two_line;
        logic       skip_cursor;
    } t_job;

    // Persistent display state.
    typedef struct packed {
        logic       bl;
        logic [2:0] flags;   // display, cursor, blink
    } t_lcd_state;

endpackage

// File: rtl/clne_decode.sv
// Request decoder: turns one LCD request into a sequencer job and the
// updated display state. Depends on clne_pkg.
module clne_decode (
    input  logic [3:0]          i_cmd,
    input  logic [7:0]          i_char_code,
    input  logic [5:0]          i_column,
    input  logic [1:0]          i_row,
    input  logic                i_flag,
    input  logic                i_dir_right,
    input  logic [1:0]          i_rows,
    input  logic [5:0]          i_cols,
    input  clne_pkg::t_lcd_state i_state,
    output clne_pkg::t_job      o_job,
    output clne_pkg::t_lcd_state o_state
);

    logic       cursor_ok;
    logic [6:0] cursor_addr;
    logic [2:0] flags_disp;
    logic [2:0] flags_cur;
    logic [2:0] flags_blink;

    assign cursor_ok   = (i_row < i_rows) && (i_column < i_cols);
    assign cursor_addr = {1'b0, i_column} + ((i_row == 2'd1) ? clne_pkg::ROW1_OFFSET : 7'd0);

    assign flags_disp  = {i_flag, i_state.flags[1:0]};
    assign flags_cur   = {i_state.flags[2], i_flag, i_state.flags[0]};
    assign flags_blink = {i_state.flags[2:1], i_flag};

    always_comb begin
        o_state           = i_state;
        o_job.kind        = clne_pkg::JOB_NONE;
        o_job.data        = 8'd0;
        o_job.rs          = 1'b0;
        o_job.bl          = i_state.bl;
        o_job.two_line    = (i_rows > 2'd1);
        o_job.skip_cursor = (i_rows == 2'd0) || (i_cols == 6'd0);
        case (clne_pkg::t_cmd'(i_cmd))
            clne_pkg::CMD_INIT: begin
                o_job.kind    = clne_pkg::JOB_INIT;
                o_job.bl      = 1'b1;
                o_state.bl    = 1'b1;
                o_state.flags = clne_pkg::FLAGS_DISP_ON;
            end
            clne_pkg::CMD_CHAR: begin
                o_job.kind = clne_pkg::JOB_BYTE;
                o_job.data = i_char_code;
                o_job.rs   = 1'b1;
            end
            clne_pkg::CMD_CURSOR: begin
                if (cursor_ok) begin
                    o_job.kind = clne_pkg::JOB_BYTE;
                    o_job.data = clne_pkg::LCD_SET_ADDR | {1'b0, cursor_addr};
                end
            end
            clne_pkg::CMD_DISPLAY: begin
                o_job.kind    = clne_pkg::JOB_BYTE;
                o_job.data    = clne_pkg::LCD_DISP_OFF | {5'd0, flags_disp};
                o_state.flags = flags_disp;
            end
            clne_pkg::CMD_CUR_SHOW: begin
                o_job.kind    = clne_pkg::JOB_BYTE;
                o_job.data    = clne_pkg::LCD_DISP_OFF | {5'd0, flags_cur};
                o_state.flags = flags_cur;
            end
            clne_pkg::CMD_BLINK: begin
                o_job.kind    = clne_pkg::JOB_BYTE;
                o_job.data    = clne_pkg::LCD_DISP_OFF | {5'd0, flags_blink};
                o_state.flags = flags_blink;
            end
            clne_pkg::CMD_SHIFT: begin
                o_job.kind = clne_pkg::JOB_BYTE;
                o_job.data = clne_pkg::LCD_CD_SHIFT | {4'd0, i_flag, i_dir_right, 2'd0};
            end
            clne_pkg::CMD_CLEAR: begin
                o_job.kind = clne_pkg::JOB_BYTE;
                o_job.data = clne_pkg::LCD_CLEAR;
            end
            clne_pkg::CMD_HOME: begin
                o_job.kind = clne_pkg::JOB_BYTE;
                o_job.data = clne_pkg::LCD_HOME;
            end
            clne_pkg::CMD_BACKLIGHT: begin
                o_job.kind = clne_pkg::JOB_PORT;
                o_job.bl   = i_flag;
                o_state.bl = i_flag;
            end
            default: begin
                o_job.kind = clne_pkg::JOB_NONE;
            end
        endcase
    end

endmodule

// File: rtl/char_lcd_nibble_command_encoder_top.sv
// Character LCD nibble command encoder, top level; depends on clne_pkg and clne_decode.
// Throughput: one expander byte per cycle while the receiver does not stall; a request
// makes a run of 4 bytes (init 33, or 29 without the cursor step; backlight 1; silent none).
// A taken request is registered as the job; its first byte then goes into the output register.
// The next request is taken in the cycle the last byte of the current run moves out.
// Reset (i_rst_n low, synchronous): backlight on, flags clear, rows 2, cols 16.
module char_lcd_nibble_command_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_cmd,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_column,
    input  logic [1:0] i_row,
    input  logic       i_flag,
    input  logic       i_dir_right,
    // expander byte channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_expander_byte,
    output logic       o_last,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    // Configuration registers.
    logic [1:0] r_rows;
    logic [5:0] r_cols;

    // Persistent display state, updated as each request transaction lands.
    clne_pkg::t_lcd_state r_state;
    clne_pkg::t_lcd_state n_state;

    // Sequencer: the current job and its byte index.
    clne_pkg::t_job r_job;
    clne_pkg::t_job n_job;
    logic           r_busy;
    logic [5:0]     r_step;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       in_take;
    logic       out_free;
    logic       fire;
    logic       seq_last;
    logic [7:0] seq_byte;

    // Byte build: nibble, enable and position within a 4-byte controller byte.
    logic [7:0] ctl_byte;
    logic [1:0] sub;
    logic [5:0] init_k;
    logic [3:0] nib;
    logic       en;

    clne_decode u_decode (
        .i_cmd         (i_cmd),
        .i_char_code   (i_char_code),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_flag        (i_flag),
        .i_dir_right   (i_dir_right),
        .i_rows        (r_rows),
        .i_cols        (r_cols),
        .i_state       (r_state),
        .o_job         (n_job),
        .o_state       (n_state)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_busy && out_free;
    // Busy sequencer stalls the request side unless its last byte leaves now.
    assign o_in_stall = r_busy && !(fire && seq_last);
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    // Init runs 9 wake-up bytes, then controller bytes of 4 port bytes each.
    assign init_k = r_step - 6'd9;

    always_comb begin
        ctl_byte = r_job.data;
        sub      = r_step[1:0];
        nib      = 4'd0;
        en       = 1'b0;
        seq_last = 1'b0;
        case (r_job.kind)
            clne_pkg::JOB_BYTE: begin
                seq_last = (r_step[1:0] == 2'd3);
            end
            clne_pkg::JOB_PORT: begin
                seq_last = 1'b1;
            end
            clne_pkg::JOB_INIT: begin
                sub      = init_k[1:0];
                seq_last = (r_step == 6'd32) || (r_job.skip_cursor && (r_step == 6'd28));
                case (init_k[4:2])
                    3'd0:    ctl_byte = clne_pkg::LCD_FUNC_SET | {4'd0, r_job.two_line, 3'd0};
                    3'd1:    ctl_byte = clne_pkg::LCD_DISP_OFF;
                    3'd2:    ctl_byte = clne_pkg::LCD_CLEAR;
                    3'd3:    ctl_byte = clne_pkg::LCD_ENTRY_MODE;
                    3'd4:    ctl_byte = r_job.skip_cursor ? clne_pkg::LCD_DISP_ON
                                                          : clne_pkg::LCD_SET_ADDR;
                    default: ctl_byte = clne_pkg::LCD_DISP_ON;
                endcase
            end
            default: begin
                seq_last = 1'b1;
            end
        endcase

        if (r_job.kind == clne_pkg::JOB_PORT) begin
            nib = 4'd0;
            en  = 1'b0;
        end else if (r_job.kind == clne_pkg::JOB_INIT && r_step == 6'd0) begin
            nib = 4'd0;
            en  = 1'b0;
        end else if (r_job.kind == clne_pkg::JOB_INIT && r_step < 6'd9) begin
            // three 0x3 nibbles then 0x2, each strobed: enable on odd steps
            nib = (r_step < 6'd7) ? 4'h3 : 4'h2;
            en  = r_step[0];
        end else begin
            nib = sub[1] ? ctl_byte[3:0] : ctl_byte[7:4];
            en  = !sub[0];
        end
    end

    assign seq_byte = {nib, r_job.bl, en, 1'b0, r_job.rs};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 2'd2;
            r_cols      <= 6'd16;
            r_state.bl  <= 1'b1;
            r_state.flags <= 3'd0;
            r_busy      <= 1'b0;
            r_step      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    clne_pkg::CFG_ROWS: r_rows <= i_cfg_data[1:0];
                    clne_pkg::CFG_COLS: r_cols <= i_cfg_data;
                    default:            r_cols <= r_cols;
                endcase
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (in_take) begin
                r_state <= n_state;
            end

            // A new request overrides the finishing run.
            if (in_take && (n_job.kind != clne_pkg::JOB_NONE)) begin
                r_busy <= 1'b1;
                r_step <= 6'd0;
            end else if (fire) begin
                if (seq_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 6'd1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_job <= n_job;
        end
        if (fire) begin
            r_out_byte <= seq_byte;
            r_out_last <= seq_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expander_byte = r_out_byte;
    assign o_last          = r_out_last;

endmodule

// File: rtl/clne_checker.sv
// Port-level checker for the character LCD nibble command encoder, bound to the top.
// Depends on char_lcd_nibble_command_encoder_top_assert.svh.
`include "char_lcd_nibble_command_encoder_top_assert.svh"

module clne_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_expander_byte,
    input logic       o_last
);

    // A stalled output transaction holds.
    `CLNE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_expander_byte) && $stable(o_last), "stalled output changed")

    // A strobe byte is always followed at once by its falling-enable twin.
    `CLNE_ASSERT_NEXT(a_strobe_pair, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_expander_byte[2], o_out_valid && (o_expander_byte == ($past(o_expander_byte) & 8'hFB)), "enable strobe not closed")

    // A run never ends with enable high.
    `CLNE_ASSERT_SAME(a_last_en_low, i_clk, i_rst_n, o_out_valid && o_last, !o_expander_byte[2], "run ends with enable set")

    // The expander is only ever written, never read.
    `CLNE_ASSERT_SAME(a_write_only, i_clk, i_rst_n, o_out_valid, !o_expander_byte[1], "read bit set")

endmodule

bind char_lcd_nibble_command_encoder_top clne_checker u_clne_checker (.*);

// File: tb/tb_char_lcd_nibble_command_encoder_top.sv
// Self-checking testbench for char_lcd_nibble_command_encoder_top.
// Drives directed and random LCD requests and checks each expander byte run against a
// scoreboard that encodes the requests itself. Depends on clne_pkg and the encoder RTL.
module tb_char_lcd_nibble_command_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;
    localparam int RUN_LIMIT       = 400000;   // cycles; worst case is far below this
    localparam int SETTLE_CYCLES   = 40;       // covers a silent request still in flight
    localparam int ITEMS_PER_PHASE = 70;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_RUN         = 33;       // init is the longest run

    // Expander port bits
    localparam logic [7:0] PORT_RS = 8'h01;
    localparam logic [7:0] PORT_EN = 8'h04;
    localparam logic [7:0] PORT_BL = 8'h08;

    // Controller byte pieces not in the package
    localparam logic [7:0] INIT_NIBBLE_8BIT = 8'h30;
    localparam logic [7:0] INIT_NIBBLE_4BIT = 8'h20;
    localparam logic [7:0] FUNC_TWO_LINE    = 8'h08;
    localparam logic [7:0] SHIFT_DISPLAY    = 8'h08;
    localparam logic [7:0] SHIFT_TO_RIGHT   = 8'h04;
    localparam logic [2:0] FLAG_CURSOR      = 3'b010;
    localparam logic [2:0] FLAG_BLINK       = 3'b001;

    // Codes outside the command set; the block drops them
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [1:0] row;
        logic       flag;
        logic       dir_right;
    } t_lcd_request;

    typedef struct packed {
        logic [7:0] port;
        logic       last;
    } t_port_beat;

    // Encodes accepted requests into expected port bytes and checks the byte stream.
    class lcd_port_scoreboard;
        logic [1:0] rows_in_use;
        logic [5:0] cols_in_use;
        logic       backlight_on;
        logic [2:0] display_flags;   // display, cursor, blink
        t_port_beat beats_due[$];
        t_port_beat run[$];
        int         errors;

        function new();
            rows_in_use   = 2'd2;
            cols_in_use   = 6'd16;
            backlight_on  = 1'b1;
            display_flags = 3'b000;
            errors        = 0;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function void emit_port(logic [7:0] v);
            t_port_beat b;
            if (run.size() >= MAX_RUN) return;
            b.port = v | (backlight_on ? PORT_BL : 8'h00);
            b.last = 1'b0;
            run.push_back(b);
        endfunction

        function void emit_nibble(logic [7:0] v);
            emit_port(v | PORT_EN);
            emit_port(v);
        endfunction

        function void emit_byte(logic [7:0] val, logic [7:0] rs);
            emit_nibble((val & 8'hF0) | rs);
            emit_nibble({val[3:0], 4'h0} | rs);
        endfunction

        function void emit_display();
            emit_byte(clne_pkg::LCD_DISP_OFF | {5'b00000, display_flags}, 8'h00);
        endfunction

        function void emit_cursor(logic [5:0] col, logic [1:0] row);
            logic [7:0] offset;
            if (row >= rows_in_use || col >= cols_in_use) return;
            offset = (row == 2'd1) ? {1'b0, clne_pkg::ROW1_OFFSET} : 8'h00;
            emit_byte(clne_pkg::LCD_SET_ADDR | ({2'b00, col} + offset), 8'h00);
        endfunction

        function void note_request(t_lcd_request req);
            logic [7:0] shift_code;
            t_port_beat tail;
            run.delete();
            case (req.cmd)
                clne_pkg::CMD_INIT: begin
                    backlight_on = 1'b1;
                    emit_port(8'h00);
                    emit_nibble(INIT_NIBBLE_8BIT);
                    emit_nibble(INIT_NIBBLE_8BIT);
                    emit_nibble(INIT_NIBBLE_8BIT);
                    emit_nibble(INIT_NIBBLE_4BIT);
                    emit_byte(clne_pkg::LCD_FUNC_SET
                              | ((rows_in_use > 2'd1) ? FUNC_TWO_LINE : 8'h00), 8'h00);
                    display_flags = 3'b000;
                    emit_display();
                    emit_byte(clne_pkg::LCD_CLEAR, 8'h00);
                    emit_byte(clne_pkg::LCD_ENTRY_MODE, 8'h00);
                    emit_cursor(6'd0, 2'd0);
                    display_flags = clne_pkg::FLAGS_DISP_ON;
                    emit_display();
                end
                clne_pkg::CMD_CHAR:   emit_byte(req.char_code, PORT_RS);
                clne_pkg::CMD_CURSOR: emit_cursor(req.column, req.row);
                clne_pkg::CMD_DISPLAY: begin
                    display_flags = req.flag ? (display_flags | clne_pkg::FLAGS_DISP_ON)
                                             : (display_flags & ~clne_pkg::FLAGS_DISP_ON);
                    emit_display();
                end
                clne_pkg::CMD_CUR_SHOW: begin
                    display_flags = req.flag ? (display_flags | FLAG_CURSOR)
                                             : (display_flags & ~FLAG_CURSOR);
                    emit_display();
                end
                clne_pkg::CMD_BLINK: begin
                    display_flags = req.flag ? (display_flags | FLAG_BLINK)
                                             : (display_flags & ~FLAG_BLINK);
                    emit_display();
                end
                clne_pkg::CMD_SHIFT: begin
                    shift_code = clne_pkg::LCD_CD_SHIFT | (req.flag ? SHIFT_DISPLAY : 8'h00)
                                 | (req.dir_right ? SHIFT_TO_RIGHT : 8'h00);
                    emit_byte(shift_code, 8'h00);
                end
                clne_pkg::CMD_CLEAR: emit_byte(clne_pkg::LCD_CLEAR, 8'h00);
                clne_pkg::CMD_HOME:  emit_byte(clne_pkg::LCD_HOME, 8'h00);
                clne_pkg::CMD_BACKLIGHT: begin
                    backlight_on = req.flag;
                    emit_port(8'h00);
                end
                default: ;
            endcase
            if (run.size() > 0) begin
                tail = run.pop_back();
                tail.last = 1'b1;
                run.push_back(tail);
            end
            foreach (run[i]) beats_due.push_back(run[i]);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_port_byte(logic [7:0] port, logic last);
            t_port_beat due;
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("port byte %02h last %0b with nothing due", port, last));
                return;
            end
            due = beats_due.pop_front();
            if (port !== due.port)
                report_mismatch($sformatf("port byte %02h, expected %02h", port, due.port));
            if (last !== due.last)
                report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                          last, due.last, due.port));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [3:0] i_cmd;
    logic [7:0] i_char_code;
    logic [5:0] i_column;
    logic [1:0] i_row;
    logic       i_flag;
    logic       i_dir_right;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_expander_byte;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [5:0] i_cfg_data;

    lcd_port_scoreboard port_sb;
    int unsigned        cycle_count;

    char_lcd_nibble_command_encoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_flag          (i_flag),
        .i_dir_right     (i_dir_right),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Every expander byte transaction is checked at the rising edge it is taken on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            port_sb.check_port_byte(o_expander_byte, o_last);
    end

    // Receiver back-pressure: modes switch after a random hold. The periodic
    // modes use periods prime to 4 so that stalls walk across the 4-byte runs.
    initial begin
        int mode;
        int hold;
        int tick;
        i_out_stall = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 4);
            hold = $urandom_range(20, 150);
            repeat (hold) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 99) < 60);
                    2:       i_out_stall = ($urandom_range(0, 99) < 15);
                    3:       i_out_stall = (tick % 3 != 0);
                    default: i_out_stall = (tick % 5 == 0);
                endcase
            end
        end
    end

    // Watchdog: reaching the limit means the block hung or lost results.
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offer one request and hold it until a transaction takes it. Valid stays
    // high when the caller sends again right away.
    task automatic send_request(t_lcd_request req);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_cmd         = req.cmd;
        i_char_code   = req.char_code;
        i_column      = req.column;
        i_row         = req.row;
        i_flag        = req.flag;
        i_dir_right   = req.dir_right;
        do @(posedge i_clk); while (o_in_stall);
        port_sb.note_request(req);
    endtask

    task automatic send_cmd(logic [3:0] cmd, logic [7:0] ch, logic [5:0] col,
                            logic [1:0] row, logic flag, logic right);
        t_lcd_request req;
        req = '{cmd: cmd, char_code: ch, column: col, row: row, flag: flag,
                dir_right: right};
        send_request(req);
    endtask

    // Sender idle for a gap set by n; command, character and column are scrambled while valid is low.
    task automatic sender_gap(int n);
        if (n == 0) return;
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cmd       = 4'($urandom);
        i_char_code = 8'($urandom);
        i_column    = 6'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait for every expected byte to come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (port_sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic index, logic [5:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == clne_pkg::CFG_ROWS)
            port_sb.rows_in_use = data[1:0];
        else
            port_sb.cols_in_use = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Config is only touched with the block idle: drained, then a settle pause
    // in case a silent request is still being worked off.
    task automatic set_geometry(logic [1:0] rows, logic [5:0] cols);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_cfg(clne_pkg::CFG_ROWS, {4'b0000, rows});
        write_cfg(clne_pkg::CFG_COLS, cols);
    endtask

    // Random request with junk in the unused fields. Cursor requests land in
    // range most of the time so the address path gets real work.
    function automatic t_lcd_request random_request();
        t_lcd_request req;
        int pick;
        req.cmd         = 4'($urandom);
        req.char_code   = 8'($urandom);
        req.column      = 6'($urandom);
        req.row         = 2'($urandom);
        req.flag        = 1'($urandom);
        req.dir_right   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            req.cmd = clne_pkg::CMD_INIT;
        end else if (pick < 32) begin
            req.cmd = clne_pkg::CMD_CHAR;
        end else if (pick < 52) begin
            req.cmd = clne_pkg::CMD_CURSOR;
            if ($urandom_range(0, 3) != 0) begin
                req.column = 6'($urandom_range(0, int'(port_sb.cols_in_use) - 1));
                req.row    = 2'($urandom_range(0, int'(port_sb.rows_in_use) - 1));
            end
        end else if (pick < 94) begin
            req.cmd = 4'($urandom_range(int'(clne_pkg::CMD_DISPLAY),
                                        int'(clne_pkg::CMD_BACKLIGHT)));
        end else begin
            req.cmd = 4'($urandom_range(int'(CMD_FIRST_UNUSED), int'(CMD_LAST_UNUSED)));
        end
        return req;
    endfunction

    initial begin
        int   sent;
        int   burst;
        logic [1:0] rows;
        logic [5:0] cols;

        port_sb       = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = clne_pkg::CMD_INIT;
        i_char_code   = 8'h00;
        i_column      = 6'd0;
        i_row         = 2'd0;
        i_flag        = 1'b0;
        i_dir_right   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = clne_pkg::CFG_ROWS;
        i_cfg_data    = 6'd0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, on the reset geometry (2 rows, 16 columns).
        send_cmd(clne_pkg::CMD_INIT,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_CHAR,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_CHAR,      8'hFF, 6'd63, 2'd3, 1'b1, 1'b1);
        send_cmd(clne_pkg::CMD_CURSOR,    8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_CURSOR,    8'h00, 6'd15, 2'd1, 1'b0, 1'b0);  // last col, row 1
        send_cmd(clne_pkg::CMD_CURSOR,    8'h00, 6'd16, 2'd0, 1'b0, 1'b0);  // col off the end
        send_cmd(clne_pkg::CMD_CURSOR,    8'h00, 6'd3,  2'd2, 1'b0, 1'b0);  // row off the end
        send_cmd(clne_pkg::CMD_CURSOR,    8'hFF, 6'd63, 2'd3, 1'b1, 1'b1);
        send_cmd(clne_pkg::CMD_DISPLAY,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_DISPLAY,   8'h00, 6'd0,  2'd0, 1'b1, 1'b0);
        send_cmd(clne_pkg::CMD_CUR_SHOW,  8'h00, 6'd0,  2'd0, 1'b1, 1'b0);
        send_cmd(clne_pkg::CMD_CUR_SHOW,  8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_BLINK,     8'h00, 6'd0,  2'd0, 1'b1, 1'b0);
        send_cmd(clne_pkg::CMD_BLINK,     8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_SHIFT,     8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_SHIFT,     8'h00, 6'd0,  2'd0, 1'b0, 1'b1);
        send_cmd(clne_pkg::CMD_SHIFT,     8'h00, 6'd0,  2'd0, 1'b1, 1'b0);
        send_cmd(clne_pkg::CMD_SHIFT,     8'h00, 6'd0,  2'd0, 1'b1, 1'b1);
        send_cmd(clne_pkg::CMD_CLEAR,     8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_HOME,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_BACKLIGHT, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_CHAR,      8'h5A, 6'd0,  2'd0, 1'b0, 1'b0);  // backlight off
        send_cmd(CMD_FIRST_UNUSED,        8'hFF, 6'd63, 2'd3, 1'b1, 1'b1);
        send_cmd(CMD_LAST_UNUSED,         8'h00, 6'd0,  2'd0, 1'b0, 1'b0);
        send_cmd(clne_pkg::CMD_INIT,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0);  // backlight back

        // Random phases, each on its own geometry, extremes first.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin rows = 2'd1; cols = 6'd1;  end
                1:       begin rows = 2'd2; cols = 6'd40; end
                2:       begin rows = 2'd1; cols = 6'd40; end
                3:       begin rows = 2'd2; cols = 6'd1;  end
                default: begin
                    rows = 2'($urandom_range(1, 2));
                    cols = 6'($urandom_range(2, 39));
                end
            endcase
            set_geometry(rows, cols);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 12);
                while (burst > 0 && sent < ITEMS_PER_PHASE) begin
                    send_request(random_request());
                    sent++;
                    burst--;
                    // In phase 2, once mid-phase, hold off until the block has emptied out.
                    if (phase == 2 && sent == ITEMS_PER_PHASE / 2)
                        wait_drained();
                end
                // A zero gap keeps valid high straight into the next burst.
                sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (port_sb.errors == 0 && port_sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: char_lcd_nibble_command_encoder_top.f
+incdir+rtl
rtl/clne_pkg.sv
rtl/clne_decode.sv
rtl/char_lcd_nibble_command_encoder_top.sv
rtl/clne_checker.sv
tb/tb_char_lcd_nibble_command_encoder_top.sv
